### rtl/mecf_pkg.sv
package mecf_pkg;

	localparam int unsigned DEPTH_DEFAULT = 1024;

	// request opcodes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// MIDI status high nibbles
	localparam logic [7:0] STATUS_TYPE_MASK = 8'hF0;
	localparam logic [7:0] STATUS_NOTE_ON   = 8'h90;
	localparam logic [7:0] STATUS_NOTE_OFF  = 8'h80;
	localparam logic [7:0] STATUS_CTRL      = 8'hB0;

	// push outcomes
	localparam logic [1:0] OUTCOME_QUEUED     = 2'd0;
	localparam logic [1:0] OUTCOME_IGNORED    = 2'd1;
	localparam logic [1:0] OUTCOME_SUPPRESSED = 2'd2;
	localparam logic [1:0] OUTCOME_DROPPED    = 2'd3;

	// command kinds
	localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
	localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
	localparam logic [1:0] KIND_CTRL     = 2'd2;

	typedef struct packed {
		logic       opcode;
		logic [7:0] status_byte;
		logic [7:0] data_one;
		logic [7:0] data_two;
	} req_t;

	typedef struct packed {
		logic [1:0]  push_outcome;
		logic        pop_valid;
		logic [1:0]  command_kind;
		logic [3:0]  channel_out;
		logic [7:0]  first_byte_out;
		logic [7:0]  second_byte_out;
		logic [31:0] drop_count;
	} rsp_t;

	// one queued command, 22 bits
	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] channel;
		logic [7:0] data_one;
		logic [7:0] data_two;
	} entry_t;

endpackage

### rtl/midi_event_command_fifo_core.sv
// Channel  Direction  Signals                          Accepted when
// req      in         req_valid, req_ready, req        req_valid && req_ready
// rsp      out        rsp_valid, rsp_ready, rsp        rsp_valid && rsp_ready
// cfg      in         cfg_we, cfg_wdata (hold mode)    cfg_we
//
// Each request produces one response: the store is read (pop) or written (push)
// at the accept edge, as stage 1 takes the request; the read data moves on into
// the response register when the output slot frees. With rsp_ready high, one
// request per cycle; the single store port and one stage register set that rate.
// A stalled response holds rsp and blocks req_ready once stage 1 is also full.
// arst_n clears pointers, drop counter, hold mode and valids; the store itself
// is not cleared, and only entries that were written are ever read.
module midi_event_command_fifo_core #(
	parameter int unsigned DEPTH = mecf_pkg::DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mecf_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mecf_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic           cfg_wdata
);
	import mecf_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	// command store, one read or one write per cycle
	entry_t mem [DEPTH];
	entry_t rd_data_q;

	logic [AW-1:0] rd_ptr_q, wr_ptr_q;
	logic [31:0]   drop_q;
	logic          hold_q;

	// stage 1: request in flight while the store read completes
	logic          v_s1;
	logic          pop_s1;
	logic          hit_s1;
	logic [1:0]    outcome_s1;
	logic [31:0]   drop_s1;

	// response register
	logic          rsp_v_q;
	rsp_t          rsp_q;

	logic          accept, advance;
	logic [7:0]    status_type;
	logic          is_on, is_off, is_ctrl, queueable, full, empty;
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_ptr_next, rd_ptr_next;
	logic [1:0]    outcome;
	logic [1:0]    kind;
	logic [31:0]   drop_next;
	entry_t        wr_entry;

	// output slot frees when empty or being taken
	assign advance   = !rsp_v_q || rsp_ready;
	assign req_ready = !v_s1 || advance;
	assign accept    = req_valid && req_ready;

	// classification
	assign status_type = req.status_byte & STATUS_TYPE_MASK;
	assign is_on   = (status_type == STATUS_NOTE_ON) && (req.data_two != 8'd0);
	assign is_off  = (status_type == STATUS_NOTE_OFF) ||
	                 ((status_type == STATUS_NOTE_ON) && (req.data_two == 8'd0));
	assign is_ctrl = (status_type == STATUS_CTRL);
	assign queueable = is_on || is_ctrl || (is_off && !hold_q);

	assign wr_ptr_next = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
	assign rd_ptr_next = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
	assign full  = (wr_ptr_next == rd_ptr_q);
	assign empty = (rd_ptr_q == wr_ptr_q);

	assign wr_en = accept && (req.opcode == OP_PUSH) && queueable && !full;
	assign rd_en = accept && (req.opcode == OP_POP) && !empty;

	always_comb begin
		if (is_on) begin
			kind = KIND_NOTE_ON;
		end else if (is_off) begin
			kind = KIND_NOTE_OFF;
		end else begin
			kind = KIND_CTRL;
		end
	end

	always_comb begin
		if (req.opcode == OP_POP) begin
			outcome = OUTCOME_QUEUED;
		end else if (!(is_on || is_off || is_ctrl)) begin
			outcome = OUTCOME_IGNORED;
		end else if (is_off && hold_q) begin
			outcome = OUTCOME_SUPPRESSED;
		end else if (full) begin
			outcome = OUTCOME_DROPPED;
		end else begin
			outcome = OUTCOME_QUEUED;
		end
	end

	// saturating drop counter
	always_comb begin
		drop_next = drop_q;
		if (accept && (req.opcode == OP_PUSH) && queueable && full &&
		    (drop_q != '1)) begin
			drop_next = drop_q + 32'd1;
		end
	end

	assign wr_entry = '{kind: kind, channel: req.status_byte[3:0],
	                    data_one: req.data_one, data_two: req.data_two};

	// store port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			drop_q   <= '0;
			hold_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				hold_q <= cfg_wdata;
			end
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_next;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_next;
			end
			drop_q <= drop_next;
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_ready) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_s1     <= (req.opcode == OP_POP);
			hit_s1     <= rd_en;
			outcome_s1 <= outcome;
			drop_s1    <= drop_next;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (advance) begin
			rsp_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			rsp_q.push_outcome <= pop_s1 ? OUTCOME_QUEUED : outcome_s1;
			rsp_q.pop_valid    <= hit_s1;
			rsp_q.drop_count   <= drop_s1;
			if (hit_s1) begin
				rsp_q.command_kind    <= rd_data_q.kind;
				rsp_q.channel_out     <= rd_data_q.channel;
				rsp_q.first_byte_out  <= rd_data_q.data_one;
				rsp_q.second_byte_out <= rd_data_q.data_two;
			end else begin
				rsp_q.command_kind    <= '0;
				rsp_q.channel_out     <= '0;
				rsp_q.first_byte_out  <= '0;
				rsp_q.second_byte_out <= '0;
			end
		end
	end

	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

	// a write never makes the ring look empty
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_ptr_next != rd_ptr_q))
		else $error("write pointer caught up with read pointer");

	// one store access per cycle
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("store read and write in the same cycle");

	// drop counter never decreases
	a_drop_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (drop_q >= $past(drop_q)))
		else $error("drop counter went backwards");

	// a stalled stage 1 keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !advance) |=> (v_s1 && $stable(hit_s1) && $stable(drop_s1)))
		else $error("stage 1 request lost under stall");

	// a returned command always reports a zero push outcome
	a_pop_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_v_q && rsp_q.pop_valid) |-> (rsp_q.push_outcome == OUTCOME_QUEUED))
		else $error("pop response carries a push outcome");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import mecf_pkg::*;

	localparam int unsigned DEPTH       = DEPTH_DEFAULT;
	localparam int unsigned RING_AW     = $clog2(DEPTH);
	localparam int unsigned CYCLE_LIMIT = 500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	// idle rates in percent, changed between phases
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	int error_count = 0;
	int unsigned cycle_count = 0;

	// shadow copy of the command ring and its counters
	entry_t      note_ring [DEPTH];
	int unsigned ring_head = 0;
	int unsigned ring_tail = 0;
	logic [31:0] drops_seen = '0;
	logic        hold_shadow = 1'b0;

	// replies owed by the block, oldest first
	rsp_t pending_replies [$];

	midi_event_command_fifo_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("midi_event_command_fifo_core test failed");
			$finish;
		end
	end

	function automatic int unsigned ring_used();
		return (ring_tail + DEPTH - ring_head) % DEPTH;
	endfunction

	// Classify a request against the shadow ring and return the reply it owes.
	// Updates the shadow state exactly as the block should.
	function automatic rsp_t predict_reply(req_t r);
		rsp_t       reply;
		entry_t     cmd;
		logic [7:0] msg_type;
		logic       to_ring;
		reply = '0;
		cmd = '0;
		msg_type = r.status_byte & STATUS_TYPE_MASK;
		to_ring = 1'b1;
		if (r.opcode == OP_PUSH) begin
			cmd.channel = r.status_byte[3:0];
			cmd.data_one = r.data_one;
			cmd.data_two = r.data_two;
			if (msg_type == STATUS_NOTE_ON && r.data_two != 8'd0) begin
				cmd.kind = KIND_NOTE_ON;
			end else if (msg_type == STATUS_NOTE_OFF || msg_type == STATUS_NOTE_ON) begin
				// note-on with zero velocity is a release too
				cmd.kind = KIND_NOTE_OFF;
				if (hold_shadow) begin
					reply.push_outcome = OUTCOME_SUPPRESSED;
					to_ring = 1'b0;
				end
			end else if (msg_type == STATUS_CTRL) begin
				cmd.kind = KIND_CTRL;
			end else begin
				reply.push_outcome = OUTCOME_IGNORED;
				to_ring = 1'b0;
			end
			if (to_ring) begin
				if ((ring_tail + 1) % DEPTH == ring_head) begin
					reply.push_outcome = OUTCOME_DROPPED;
					if (drops_seen != '1)
						drops_seen = drops_seen + 1;
				end else begin
					note_ring[ring_tail[RING_AW-1:0]] = cmd;
					ring_tail = (ring_tail + 1) % DEPTH;
					reply.push_outcome = OUTCOME_QUEUED;
				end
			end
		end else if (ring_head != ring_tail) begin
			cmd = note_ring[ring_head[RING_AW-1:0]];
			ring_head = (ring_head + 1) % DEPTH;
			reply.pop_valid = 1'b1;
			reply.command_kind = cmd.kind;
			reply.channel_out = cmd.channel;
			reply.first_byte_out = cmd.data_one;
			reply.second_byte_out = cmd.data_two;
		end
		reply.drop_count = drops_seen;
		return reply;
	endfunction

	// Mostly well-formed channel messages, some raw status noise.
	function automatic req_t random_request(int pop_pct);
		req_t r;
		r.opcode = ($urandom_range(99) < pop_pct) ? OP_POP : OP_PUSH;
		r.data_one = 8'($urandom);
		r.data_two = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
		case ($urandom_range(9))
			0, 1, 2: r.status_byte = {STATUS_NOTE_ON[7:4], 4'($urandom)};
			3, 4:    r.status_byte = {STATUS_NOTE_OFF[7:4], 4'($urandom)};
			5, 6:    r.status_byte = {STATUS_CTRL[7:4], 4'($urandom)};
			default: r.status_byte = 8'($urandom);
		endcase
		return r;
	endfunction

	function automatic req_t make_push(logic [7:0] status, logic [7:0] d1, logic [7:0] d2);
		req_t r;
		r.opcode = OP_PUSH;
		r.status_byte = status;
		r.data_one = d1;
		r.data_two = d2;
		return r;
	endfunction

	// Called at a rising edge; returns at the edge where the request is taken.
	// Valid stays high on return so back-to-back requests need no re-raise.
	task automatic send_request(req_t r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (!req_ready);
		pending_replies.push_back(predict_reply(r));
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// hold mode only changes with nothing in flight
	task automatic write_hold(logic v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		hold_shadow = v;
	endtask

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s expected %0h got %0h", $time, name, exp_val, got_val);
			error_count++;
		end
	endtask

	// Response side: check each accepted reply, then pick next cycle's ready.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected reply, expected none got %0h", $time, rsp);
				error_count++;
			end else begin
				want = pending_replies.pop_front();
				check_field("push_outcome", 32'(want.push_outcome),
				            32'(rsp.push_outcome));
				check_field("pop_valid", 32'(want.pop_valid), 32'(rsp.pop_valid));
				check_field("command_kind", 32'(want.command_kind),
				            32'(rsp.command_kind));
				check_field("channel_out", 32'(want.channel_out),
				            32'(rsp.channel_out));
				check_field("first_byte_out", 32'(want.first_byte_out),
				            32'(rsp.first_byte_out));
				check_field("second_byte_out", 32'(want.second_byte_out),
				            32'(rsp.second_byte_out));
				check_field("drop_count", want.drop_count, rsp.drop_count);
			end
		end
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Empty pop, field extremes and every status class with hold off.
	task automatic test_classify();
		req_t pop_req;
		pop_req = '{opcode: OP_POP, status_byte: 8'hFF, data_one: 8'hFF, data_two: 8'hFF};
		write_hold(1'b0);
		send_request(pop_req);
		send_request(make_push(8'h90, 8'h00, 8'h01));
		send_request(make_push(8'h9F, 8'hFF, 8'hFF));
		send_request(make_push(8'h95, 8'h3C, 8'h00));
		send_request(make_push(8'h80, 8'h40, 8'h40));
		send_request(make_push(8'h8F, 8'hFF, 8'h00));
		send_request(make_push(8'hB0, 8'h00, 8'h00));
		send_request(make_push(8'hBF, 8'hFF, 8'hFF));
		send_request(make_push(8'h00, 8'h12, 8'h34));
		send_request(make_push(8'hA5, 8'h55, 8'hAA));
		send_request(make_push(8'hF0, 8'h00, 8'h00));
		send_request(make_push(8'hFF, 8'hFF, 8'hFF));
		repeat (8)
			send_request(random_request(100));
	endtask

	// Note-offs and zero-velocity note-ons are swallowed under hold.
	task automatic test_hold_mode();
		write_hold(1'b1);
		send_request(make_push(8'h80, 8'h30, 8'h7F));
		send_request(make_push(8'h93, 8'h30, 8'h00));
		send_request(make_push(8'h93, 8'h30, 8'h0A));
		send_request(make_push(8'hB2, 8'h07, 8'h64));
		repeat (3)
			send_request(random_request(100));
	endtask

	// Fill to DEPTH-1 with queueable messages, overflow, then drain a few.
	task automatic test_ring_full();
		logic [3:0] fill_type;
		write_hold(1'b0);
		while (ring_used() < DEPTH - 1) begin
			case ($urandom_range(2))
				0:       fill_type = STATUS_NOTE_ON[7:4];
				1:       fill_type = STATUS_NOTE_OFF[7:4];
				default: fill_type = STATUS_CTRL[7:4];
			endcase
			send_request(make_push({fill_type, 4'($urandom)}, 8'($urandom),
			                       8'($urandom)));
		end
		repeat (8)
			send_request(random_request(0));
		// under hold a note-off is suppressed, not counted as a drop
		write_hold(1'b1);
		send_request(make_push(8'h81, 8'h22, 8'h33));
		send_request(make_push(8'h91, 8'h22, 8'h33));
		repeat (16)
			send_request(random_request(100));
	endtask

	task automatic test_random_traffic(int sender_idle, int receiver_idle);
		wait_drained();
		send_idle_pct = sender_idle;
		recv_idle_pct = receiver_idle;
		write_hold(1'b0);
		repeat (80)
			send_request(random_request(35));
		write_hold(1'b1);
		repeat (80)
			send_request(random_request(55));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 30;
		recv_idle_pct = 86;
		test_classify();
		test_hold_mode();
		test_ring_full();
		test_random_traffic(30, 86);
		test_random_traffic(86, 30);
		test_random_traffic(0, 0);

		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0 && pending_replies.size() == 0)
			$display("midi_event_command_fifo_core test passed");
		else
			$display("midi_event_command_fifo_core test failed");
		$finish;
	end

endmodule

### sim.f
rtl/mecf_pkg.sv
rtl/midi_event_command_fifo_core.sv
test/tb_top.sv
